/* hdl/ffdf_pkg.sv */
// ---------------------------------------------------------------------------
// ffdf_pkg: shared types and constants of the frame fingerprint dedup filter
// Table geometry, hash constants, register indexes and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffdf_pkg;

  // table and timestamp geometry
  localparam int TABLE_ENTRIES     = 16384;
  localparam int SLOT_BITS         = $clog2(TABLE_ENTRIES);
  localparam int HASH_PREFIX_BYTES = 64;
  localparam int COUNT_BITS        = 7;
  localparam int TIME_BITS         = 48;
  localparam int CFG_DATA_BITS     = 48;

  // FNV-1a 32-bit
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  localparam logic [CFG_DATA_BITS-1:0] LIFETIME_RESET = CFG_DATA_BITS'(5000000);
  localparam logic [COUNT_BITS-1:0]    PREFIX_LIMIT   = COUNT_BITS'(HASH_PREFIX_BYTES);
  localparam logic [SLOT_BITS-1:0]     LAST_SLOT      = SLOT_BITS'(TABLE_ENTRIES - 1);

  // register indexes
  localparam logic [0:0] REG_FILTER_ENABLE  = 1'b0;
  localparam logic [0:0] REG_LIFETIME_TICKS = 1'b1;

  // frame direction
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_LOOKUP
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0]          hash;
    logic [TIME_BITS-1:0] expiry;
  } slot_entry_t;

  // one FNV-1a step: (h ^ b) * 16777619, the prime being 2^24 + 403
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

/* hdl/frame_fingerprint_dedup_filter_top.sv */
// ---------------------------------------------------------------------------
// frame_fingerprint_dedup_filter_top: duplicate frame suppression filter
// Hashes the first bytes of each frame (FNV-1a) and records outgoing frames
// in a direct-mapped fingerprint table, dropping one matching incoming copy.
// ---------------------------------------------------------------------------
// After reset the block holds busy while it zeroes the fingerprint table,
// one entry per cycle. Then it takes one byte per cycle while busy is low.
// After the last byte of a frame busy rises for one cycle while the table
// entry, read through the memory's registered read port, is compared and,
// if needed, written back. The result beat (done, drop_frame, fingerprint)
// appears for one cycle, registered from the lookup state; there is no stall
// from the receiver, so it must sample done whenever it is high.
`timescale 1ns / 1ps
`default_nettype none

module frame_fingerprint_dedup_filter_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // byte input
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                op,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                frame_end,
  input  wire logic [ffdf_pkg::TIME_BITS-1:0]      now_time,
  // result
  output logic                                     done,
  output logic                                     drop_frame,
  output logic [31:0]                              fingerprint,
  // configuration
  input  wire logic                                wr_en,
  input  wire logic [0:0]                          wr_index,
  input  wire logic [ffdf_pkg::CFG_DATA_BITS-1:0]  wr_data
);
  import ffdf_pkg::*;

  ctrl_state_t state, state_next;

  logic                     filter_enable;
  logic [CFG_DATA_BITS-1:0] lifetime_ticks;

  logic [31:0]           running_hash;
  logic [COUNT_BITS-1:0] bytes_hashed;
  logic [SLOT_BITS-1:0]  clr_count;

  // lookup stage
  logic [31:0]          lk_hash;
  logic                 lk_op;
  logic [TIME_BITS-1:0] lk_now;

  // fingerprint memory
  slot_entry_t          table_mem [TABLE_ENTRIES];
  slot_entry_t          rd_entry;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  slot_entry_t          mem_wdata;

  logic                 accept;
  logic [31:0]          hash_next;
  logic [TIME_BITS:0]   expiry_sum;
  logic [TIME_BITS-1:0] expiry_new;
  logic                 hit;

  assign accept = start && !busy;

  // hash fold for the prefix bytes only
  always_comb begin
    if (bytes_hashed < PREFIX_LIMIT) begin
      hash_next = fnv_step(running_hash, data_byte);
    end else begin
      hash_next = running_hash;
    end
  end

  // expiry = now + lifetime, saturating
  assign expiry_sum = {1'b0, lk_now} + {1'b0, lifetime_ticks[TIME_BITS-1:0]};
  assign expiry_new = expiry_sum[TIME_BITS] ? '1 : expiry_sum[TIME_BITS-1:0];

  assign hit = (rd_entry.hash == lk_hash) && (rd_entry.expiry > lk_now);

  // controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, busy and memory write port
  always_comb begin
    state_next       = state;
    busy             = 1'b1;
    mem_we           = 1'b0;
    mem_waddr        = lk_hash[SLOT_BITS-1:0];
    mem_wdata.hash   = lk_hash;
    mem_wdata.expiry = expiry_new;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_count;
        mem_wdata = '0;
        if (clr_count == LAST_SLOT) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b0;
        if (accept && frame_end) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_RUN;
        if (filter_enable) begin
          if (lk_op == OP_RECORD) begin
            mem_we = 1'b1;
          end else if (hit) begin
            // consume the entry so only one copy is dropped
            mem_we           = 1'b1;
            mem_wdata.hash   = rd_entry.hash;
            mem_wdata.expiry = '0;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // fingerprint memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (accept && frame_end) begin
      rd_entry <= table_mem[hash_next[SLOT_BITS-1:0]];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (state == ST_CLEAR) begin
      clr_count <= clr_count + SLOT_BITS'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable  <= 1'b0;
      lifetime_ticks <= LIFETIME_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FILTER_ENABLE:  filter_enable  <= wr_data[0];
        REG_LIFETIME_TICKS: lifetime_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  // running hash and prefix count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      bytes_hashed <= '0;
    end else if (accept) begin
      if (frame_end) begin
        running_hash <= FNV_BASIS;
        bytes_hashed <= '0;
      end else begin
        running_hash <= hash_next;
        if (bytes_hashed < PREFIX_LIMIT) begin
          bytes_hashed <= bytes_hashed + COUNT_BITS'(1);
        end
      end
    end
  end

  // capture the finished frame for the lookup cycle
  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      lk_hash <= hash_next;
      lk_op   <= op;
      lk_now  <= now_time;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      drop_frame  <= filter_enable && (lk_op == OP_CHECK) && hit;
      fingerprint <= lk_hash;
    end
  end

endmodule

`default_nettype wire
